[hdl/dde_pkg.sv]
// ----------------------------------------------------------------------------
// dde_pkg
// Shared types, widths and constants for the decision-directed LMS equalizer.
// ----------------------------------------------------------------------------
package dde_pkg;

    localparam int SMP_W   = 16;
    localparam int TAP_W   = 24;
    localparam int STEP_W  = 16;
    localparam int GATE_W  = 14;
    localparam int LEAK_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_TAP_COUNT = 64;
    localparam int DEF_PRE_TAPS  = 8;

    localparam logic signed [TAP_W-1:0] TAP_ONE  = 24'sd65536;
    localparam logic signed [TAP_W-1:0] TAP_MAXV = 24'sd8388607;
    localparam logic signed [TAP_W-1:0] TAP_MINV = -24'sd8388608;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd5033;
    localparam logic [GATE_W-1:0] GATE_RESET = 14'd2048;
    localparam logic [LEAK_W-1:0] LEAK_RESET = 16'd0;

    // divergence limit: 2500 in Q.32
    localparam logic [63:0] BAIL_ENERGY = 64'd2500 << 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE   = 2'd0,
        REG_ERROR_GATE  = 2'd1,
        REG_LEAK_FACTOR = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_in;
        logic                    segment_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] equalized_sample;
        logic                    segment_end_out;
        logic                    taps_restored;
    } out_item_t;

    // control for the row of cells
    typedef struct packed {
        logic shift;
        logic rotate;
        logic restore;
    } cell_ctrl_t;

    // control for the arithmetic unit at the head of the row
    typedef struct packed {
        logic clear;
        logic dot;
        logic update;
        logic leak;
        logic energy;
    } head_ctrl_t;

    function automatic logic signed [TAP_W-1:0] clamp_tap(input logic signed [TAP_W+1:0] v);
        if (v > $signed({{2{TAP_MAXV[TAP_W-1]}}, TAP_MAXV})) begin
            return TAP_MAXV;
        end else if (v < $signed({{2{TAP_MINV[TAP_W-1]}}, TAP_MINV})) begin
            return TAP_MINV;
        end
        return v[TAP_W-1:0];
    endfunction

endpackage

[hdl/decision_directed_lms_equalizer.sv]
// ----------------------------------------------------------------------------
// decision_directed_lms_equalizer
// Adaptive FIR equalizer for 8-VSB symbols with decision-directed LMS update.
// ----------------------------------------------------------------------------
// usage:
//   s_valid/s_ready/s_data carry one received sample and its segment-end flag.
//   m_valid/m_ready/m_data return one equalized sample per input item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write step size (0), error gate (1)
//   and leak factor (2); cfg_ready is always high, write only while idle.
// sequence, N = TAP_COUNT:
//   the taps and samples sit in a ring of N cells that rotates past the
//   arithmetic unit at the head, one tap per cycle
//   plain item: accept, shift, dot-product pass, round, decide, scale, update
//   pass (when adapting), out; a segment end adds a leak pass (when leak is
//   nonzero) and an energy pass before out
// reset: samples clear to zero, taps load the unit impulse at the pre-tap
//   position, registers take their default values; no clearing pass
// stall: the result waits in the output register; the next item is taken and
//   processed, and only its final write-back waits until m_ready frees it
// ----------------------------------------------------------------------------
module decision_directed_lms_equalizer
    import dde_pkg::*;
#(
    parameter int TAP_COUNT = DEF_TAP_COUNT,
    parameter int PRE_TAPS  = DEF_PRE_TAPS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(TAP_COUNT);
    localparam int ACC_W = SMP_W + TAP_W + CNT_W;
    localparam int Y_W   = ACC_W - 16;
    localparam int E_W   = Y_W + 1;
    localparam int EN_W  = 2 * TAP_W + CNT_W;
    localparam int IMP_IDX = (PRE_TAPS < TAP_COUNT) ? PRE_TAPS : TAP_COUNT - 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TAP_COUNT - 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SHIFT  = 10'b0000000010,
        ST_DOT    = 10'b0000000100,
        ST_ROUND  = 10'b0000001000,
        ST_DECIDE = 10'b0000010000,
        ST_SCALE  = 10'b0000100000,
        ST_UPDATE = 10'b0001000000,
        ST_LEAK   = 10'b0010000000,
        ST_ENERGY = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    logic [STEP_W-1:0] step_reg;
    logic [GATE_W-1:0] gate_reg;
    logic [LEAK_W-1:0] leak_reg;

    logic signed [SMP_W-1:0] x_reg;
    logic                    seg_reg;
    logic signed [Y_W-1:0]   y_reg;
    logic signed [E_W-1:0]   e_reg;
    logic                    adapt_reg;
    logic signed [31:0]      se_reg;
    logic                    restored_reg, restored_next;
    logic                    check_reg;

    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    cell_ctrl_t cctrl;
    head_ctrl_t hctrl;

    logic signed [SMP_W-1:0] smp_q [TAP_COUNT];
    logic signed [TAP_W-1:0] tap_q [TAP_COUNT];
    logic signed [TAP_W-1:0] head_tap;
    logic signed [ACC_W-1:0] acc;
    logic [EN_W-1:0]         energy;
    logic [TAP_W:0]          keep;

    logic signed [ACC_W-1:0] acc_r;
    logic signed [E_W-1:0]   y_ext, a_y, lvl, e_val, a_e;
    logic signed [SMP_W-1:0] y_sat;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
            gate_reg <= GATE_RESET;
            leak_reg <= LEAK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP_SIZE:   step_reg <= cfg_data;
                REG_ERROR_GATE:  gate_reg <= cfg_data[GATE_W-1:0];
                REG_LEAK_FACTOR: leak_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign keep = (TAP_W+1)'(25'd1 << 24) - (TAP_W+1)'(leak_reg);

    // ---------------- row of cells ----------------
    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
        logic signed [SMP_W-1:0] s_nb;
        logic signed [TAP_W-1:0] t_nb;
        if (k == TAP_COUNT - 1) begin : g_tail
            assign s_nb = cctrl.shift ? x_reg : smp_q[0];
            assign t_nb = head_tap;
        end else begin : g_mid
            assign s_nb = smp_q[k+1];
            assign t_nb = tap_q[k+1];
        end
        dde_cell #(
            .IS_IMPULSE (k == IMP_IDX)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cctrl),
            .sample_nb (s_nb),
            .tap_nb    (t_nb),
            .sample_q  (smp_q[k]),
            .tap_q     (tap_q[k])
        );
    end

    dde_head #(
        .ACC_W (ACC_W),
        .EN_W  (EN_W)
    ) u_head (
        .aclk    (aclk),
        .ctrl    (hctrl),
        .x       (smp_q[0]),
        .t       (tap_q[0]),
        .se      (se_reg),
        .keep    (keep),
        .tap_out (head_tap),
        .acc     (acc),
        .energy  (energy)
    );

    // ---------------- decision logic ----------------
    assign acc_r = acc + ACC_W'(32768);
    assign y_ext = E_W'(y_reg);
    assign a_y   = y_reg[Y_W-1] ? -y_ext : y_ext;

    always_comb begin
        if (a_y >= E_W'(6144))      lvl = E_W'(7168);
        else if (a_y >= E_W'(4096)) lvl = E_W'(5120);
        else if (a_y >= E_W'(2048)) lvl = E_W'(3072);
        else                        lvl = E_W'(1024);
    end

    assign e_val = y_reg[Y_W-1] ? y_ext + lvl : y_ext - lvl;
    assign a_e   = e_val[E_W-1] ? -e_val : e_val;

    always_comb begin
        if (y_reg > $signed(Y_W'(32767)))       y_sat = 16'sh7fff;
        else if (y_reg < -$signed(Y_W'(32768))) y_sat = 16'sh8000;
        else                                    y_sat = y_reg[SMP_W-1:0];
    end

    // ring position wraps after the last cell for any tap count
    assign cnt_inc = (cnt_reg == LAST) ? '0 : cnt_reg + 1'b1;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        restored_next = restored_reg;
        cctrl         = '0;
        hctrl         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cctrl.shift   = 1'b1;
                hctrl.clear   = 1'b1;
                cnt_next      = '0;
                restored_next = 1'b0;
                state_next    = ST_DOT;
            end
            ST_DOT: begin
                cctrl.rotate = 1'b1;
                hctrl.dot    = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_reg == LAST) state_next = ST_ROUND;
            end
            ST_ROUND: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cnt_next = '0;
                if (adapt_reg)                        state_next = ST_UPDATE;
                else if (seg_reg && leak_reg != '0)   state_next = ST_LEAK;
                else if (seg_reg)                     state_next = ST_ENERGY;
                else                                  state_next = ST_OUT;
            end
            ST_UPDATE: begin
                cctrl.rotate = 1'b1;
                hctrl.update = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_reg == LAST) begin
                    if (seg_reg && leak_reg != '0) state_next = ST_LEAK;
                    else if (seg_reg)              state_next = ST_ENERGY;
                    else                           state_next = ST_OUT;
                end
            end
            ST_LEAK: begin
                cctrl.rotate = 1'b1;
                hctrl.leak   = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_reg == LAST) state_next = ST_ENERGY;
            end
            ST_ENERGY: begin
                cctrl.rotate = 1'b1;
                hctrl.energy = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_reg == LAST) state_next = ST_OUT;
            end
            ST_OUT: begin
                // energy check runs once, on the first cycle here
                if (check_reg && energy > EN_W'(BAIL_ENERGY)) begin
                    cctrl.restore = 1'b1;
                    restored_next = 1'b1;
                end
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            restored_reg <= 1'b0;
            check_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            restored_reg <= restored_next;
            check_reg    <= (state_reg == ST_ENERGY) && (cnt_reg == LAST);
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            x_reg   <= s_data.sample_in;
            seg_reg <= s_data.segment_end;
        end
        if (state_reg == ST_ROUND) begin
            y_reg <= acc_r[ACC_W-1:16];
        end
        if (state_reg == ST_DECIDE) begin
            e_reg     <= e_val;
            adapt_reg <= (step_reg != '0) && (a_e <= E_W'(gate_reg));
        end
        if (state_reg == ST_SCALE) begin
            se_reg <= $signed({1'b0, step_reg}) * $signed(e_reg[14:0]);
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg.equalized_sample <= y_sat;
            m_data_reg.segment_end_out  <= seg_reg;
            m_data_reg.taps_restored    <= restored_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_restore_only_on_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.taps_restored || m_data.segment_end_out))
        else $error("taps restored on a sample that is not a segment end");

    a_accept_starts_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SHIFT))
        else $error("accepted item did not start a shift");

    a_pass_starts_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DOT && $past(state_reg) == ST_SHIFT) |-> (cnt_reg == '0))
        else $error("ring pass started at a nonzero position");
`endif

endmodule

[hdl/dde_cell.sv]
// ----------------------------------------------------------------------------
// dde_cell
// One stage of the delay line: holds one sample and one tap weight.
// ----------------------------------------------------------------------------
module dde_cell
    import dde_pkg::*;
#(
    parameter bit IS_IMPULSE = 1'b0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_ctrl_t              ctrl,
    input  logic signed [SMP_W-1:0] sample_nb,
    input  logic signed [TAP_W-1:0] tap_nb,
    output logic signed [SMP_W-1:0] sample_q,
    output logic signed [TAP_W-1:0] tap_q
);

    logic signed [SMP_W-1:0] sample_reg;
    logic signed [TAP_W-1:0] tap_reg;
    logic signed [TAP_W-1:0] impulse_val;

    assign impulse_val = IS_IMPULSE ? TAP_ONE : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            tap_reg    <= impulse_val;
        end else begin
            if (ctrl.shift || ctrl.rotate) begin
                sample_reg <= sample_nb;
            end
            if (ctrl.restore) begin
                tap_reg <= impulse_val;
            end else if (ctrl.rotate) begin
                tap_reg <= tap_nb;
            end
        end
    end

    assign sample_q = sample_reg;
    assign tap_q    = tap_reg;

endmodule

[hdl/dde_head.sv]
// ----------------------------------------------------------------------------
// dde_head
// Arithmetic at the head of the ring: dot product, tap update, leak, energy.
// ----------------------------------------------------------------------------
module dde_head
    import dde_pkg::*;
#(
    parameter int ACC_W = 46,
    parameter int EN_W  = 54
) (
    input  logic                    aclk,
    input  head_ctrl_t              ctrl,
    input  logic signed [SMP_W-1:0] x,
    input  logic signed [TAP_W-1:0] t,
    input  logic signed [31:0]      se,
    input  logic [TAP_W:0]          keep,
    output logic signed [TAP_W-1:0] tap_out,
    output logic signed [ACC_W-1:0] acc,
    output logic [EN_W-1:0]         energy
);

    logic signed [ACC_W-1:0] acc_reg;
    logic [EN_W-1:0]         energy_reg;
    logic signed [SMP_W+TAP_W-1:0] prod_dot;
    logic signed [47:0]      prod_upd;
    logic signed [47:0]      prod_upd_r;
    logic signed [TAP_W+1:0] upd_diff;
    logic signed [TAP_W+TAP_W+1:0] prod_leak;
    logic signed [TAP_W+TAP_W+1:0] prod_leak_r;
    logic signed [2*TAP_W-1:0] prod_sq;

    assign prod_dot   = x * t;
    assign prod_upd   = se * x;
    assign prod_upd_r = prod_upd + 48'sd134217728;
    assign upd_diff   = {{2{t[TAP_W-1]}}, t}
                      - {{6{prod_upd_r[47]}}, prod_upd_r[47:28]};
    assign prod_leak  = t * $signed({1'b0, keep});
    assign prod_leak_r = prod_leak + (50'sd1 <<< 23);
    assign prod_sq    = t * t;

    always_comb begin
        tap_out = t;
        if (ctrl.update) begin
            tap_out = clamp_tap(upd_diff);
        end else if (ctrl.leak) begin
            tap_out = clamp_tap(prod_leak_r[TAP_W+TAP_W+1:TAP_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg    <= '0;
            energy_reg <= '0;
        end else begin
            if (ctrl.dot) begin
                acc_reg <= acc_reg + ACC_W'(prod_dot);
            end
            if (ctrl.energy) begin
                energy_reg <= energy_reg + EN_W'(prod_sq[2*TAP_W-2:0]);
            end
        end
    end

    assign acc    = acc_reg;
    assign energy = energy_reg;

endmodule

[tb/dde_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dde_scoreboard
// Watches the sample, result and register channels of the equalizer, keeps
// its own copy of the delay line, taps and registers, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module dde_scoreboard
    import dde_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int NT = DEF_TAP_COUNT;
    localparam int IMP = (DEF_PRE_TAPS < NT) ? DEF_PRE_TAPS : NT - 1;

    longint    window[NT];
    longint    taps[NT];
    longint    mu;
    longint    gate;
    longint    leak;
    out_item_t expected_q[$];

    function automatic longint sat_tap(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void load_impulse();
        foreach (taps[k]) taps[k] = 0;
        taps[IMP] = 65536;
    endfunction

    function automatic out_item_t equalize(in_item_t it);
        longint         acc, y, a, lvl, e, se, keepv;
        longint unsigned energy;
        out_item_t      r;
        acc = 0;
        for (int k = 0; k < NT - 1; k++) window[k] = window[k + 1];
        window[NT - 1] = longint'(it.sample_in);
        for (int k = 0; k < NT; k++) acc += window[k] * taps[k];
        y = rnd_shift(acc, 16);
        r.equalized_sample = (y > 32767) ? 16'sh7fff : ((y < -32768) ? 16'sh8000 : y[15:0]);
        r.segment_end_out = it.segment_end;
        r.taps_restored = 1'b0;
        if (mu != 0) begin
            a = (y < 0) ? -y : y;
            lvl = (a >= 6144) ? 7168 : ((a >= 4096) ? 5120 : ((a >= 2048) ? 3072 : 1024));
            e = y - ((y >= 0) ? lvl : -lvl);
            if (((e < 0) ? -e : e) <= gate) begin
                se = mu * e;
                for (int k = 0; k < NT; k++)
                    taps[k] = sat_tap(taps[k] - rnd_shift(se * window[k], 28));
            end
        end
        if (it.segment_end) begin
            if (leak != 0) begin
                keepv = (64'sd1 <<< 24) - leak;
                for (int k = 0; k < NT; k++) taps[k] = sat_tap(rnd_shift(taps[k] * keepv, 24));
            end
            energy = 0;
            for (int k = 0; k < NT; k++) energy += longint'(taps[k] * taps[k]);
            if (energy > BAIL_ENERGY) begin
                load_impulse();
                r.taps_restored = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            foreach (window[k]) window[k] = 0;
            load_impulse();
            mu = STEP_RESET;
            gate = GATE_RESET;
            leak = LEAK_RESET;
            expected_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_STEP_SIZE:   mu = cfg_data;
                    REG_ERROR_GATE:  gate = cfg_data[GATE_W-1:0];
                    REG_LEAK_FACTOR: leak = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_q.push_back(equalize(s_data));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item: %h", m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (want.equalized_sample !== m_data.equalized_sample ||
                        want.segment_end_out !== m_data.segment_end_out ||
                        want.taps_restored !== m_data.taps_restored) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp y=%0d seg=%b rst=%b, got y=%0d seg=%b rst=%b",
                                     want.equalized_sample, want.segment_end_out,
                                     want.taps_restored, m_data.equalized_sample,
                                     m_data.segment_end_out, m_data.taps_restored);
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

[tb/decision_directed_lms_equalizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decision_directed_lms_equalizer_test
// Drives 8-VSB like symbol streams and raw noise through the equalizer under
// several register settings and handshake idle patterns; the scoreboard
// predicts and checks every equalized sample.
// ----------------------------------------------------------------------------
module decision_directed_lms_equalizer_test;
    import dde_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    n_sent;
    int                    n_recv;
    int                    idle_mode;
    int                    quiet_cycles;
    int                    seg_count;

    decision_directed_lms_equalizer i_dut (.*);

    dde_scoreboard i_scoreboard (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // idle_mode 0: sender rarely idle, receiver mostly; 1: swapped; 2: none
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (idle_mode)
                0: m_ready <= ($urandom_range(99) >= 77);
                1: m_ready <= ($urandom_range(99) >= 7);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_recv <= 0;
        end else if (m_valid && m_ready) begin
            n_recv <= n_recv + 1;
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 40000) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic signed [15:0] smp, input logic seg);
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 7 : ((idle_mode == 1) ? 77 : 0);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{sample_in: smp, segment_end: seg};
        n_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly symbol levels with small noise and regular segment ends
    task automatic random_item();
        logic signed [15:0] smp;
        logic               seg;
        int                 lvl;
        if ($urandom_range(99) < 85) begin
            lvl = 2 * int'($urandom_range(7)) - 7;
            smp = 16'(lvl * 1024 + int'($urandom_range(600)) - 300);
            seg_count++;
            seg = (seg_count >= 24 + $urandom_range(16));
            if (seg) seg_count = 0;
        end else begin
            smp = 16'($urandom);
            seg = 1'($urandom_range(1));
        end
        send_item(smp, seg);
    endtask

    logic [15:0] set_step[5] = '{16'd0, 16'd65535, 16'd1000, 16'd20000, 16'd5033};
    logic [15:0] set_gate[5] = '{16'd0, 16'd16383, 16'd1024, 16'd16383, 16'd2048};
    logic [15:0] set_leak[5] = '{16'd0, 16'd65535, 16'd300, 16'd0, 16'd0};

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_sent = 0;
        idle_mode = 2;
        seg_count = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, zero, every level sign, segment ends
        send_item(16'sd0, 1'b0);
        send_item(16'sd32767, 1'b0);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd32767, 1'b1);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd7168, 1'b0);
        send_item(-16'sd7168, 1'b0);
        send_item(16'sd6144, 1'b0);
        send_item(16'sd4096, 1'b0);
        send_item(-16'sd2048, 1'b0);
        send_item(16'sd2047, 1'b0);
        send_item(16'sd1024, 1'b1);
        send_item(-16'sd32768, 1'b1);
        send_item(16'sd0, 1'b1);
        for (int i = 0; i < 6; i++) send_item(16'sh5555 ^ {16{i[0]}}, i[1]);

        for (int p = 0; p < 5; p++) begin
            wait_drained();
            write_reg(REG_STEP_SIZE, set_step[p]);
            write_reg(REG_ERROR_GATE, set_gate[p]);
            write_reg(REG_LEAK_FACTOR, set_leak[p]);
            for (int i = 0; i < 206; i++) begin
                idle_mode = (i * 3) / 206;
                // the sender holds off once until the block is empty
                if (p == 2 && i == 100) wait_drained();
                random_item();
            end
        end

        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/dde_pkg.sv
hdl/dde_cell.sv
hdl/dde_head.sv
hdl/decision_directed_lms_equalizer.sv
tb/dde_scoreboard.sv
tb/decision_directed_lms_equalizer_test.sv
